@@ sv/bcc_pkg.sv @@
// bcc_pkg: shared constants for the bubble cassette controller
// no dependencies
`default_nettype none
package bcc_pkg;
    localparam logic [2:0] RA_DATA   = 3'd0;
    localparam logic [2:0] RA_CMD    = 3'd1;
    localparam logic [2:0] RA_STATUS = 3'd2;
    localparam logic [2:0] RA_ERROR  = 3'd3;
    localparam logic [2:0] RA_PA_HI  = 3'd4;
    localparam logic [2:0] RA_PA_LO  = 3'd5;
    localparam logic [2:0] RA_PC_HI  = 3'd6;
    localparam logic [2:0] RA_PC_LO  = 3'd7;

    localparam logic [7:0] CMD_READ  = 8'd1;
    localparam logic [7:0] CMD_WRITE = 8'd2;
    localparam logic [7:0] CMD_CLR_A = 8'd4;
    localparam logic [7:0] CMD_CLR_B = 8'd15;

    localparam logic [1:0] CFG_INSERTED = 2'd0;
    localparam logic [1:0] CFG_LARGE    = 2'd1;
    localparam logic [1:0] CFG_PROTECT  = 2'd2;

    // status flag bit positions
    localparam int ST_BUSY = 0;
    localparam int ST_ERR  = 1;
    localparam int ST_RDA  = 2;
    localparam int ST_TDRA = 3;
    localparam int ST_CMDE = 4;

    // error flag bit positions
    localparam int ER_UNDEF  = 0;
    localparam int ER_NOMARK = 1;
    localparam int ER_POVR   = 5;
    localparam int ER_EJECT  = 6;

    localparam int AD_READ  = 0;
    localparam int AD_WRITE = 1;

    localparam logic [10:0] MASK_SMALL = 11'h3ff;
    localparam logic [10:0] MASK_LARGE = 11'h7ff;
    localparam logic [6:0]  PS_SMALL   = 7'h20;
    localparam logic [6:0]  PS_LARGE   = 7'h40;
    localparam logic [23:0] MS_SMALL   = 24'h8000;
    localparam logic [23:0] MS_LARGE   = 24'h20000;
endpackage
`default_nettype wire

@@ sv/bubble_cassette_controller.sv @@
// bubble_cassette_controller: bus register front end with media store
// depends on bcc_pkg
`default_nettype none
//  channel | direction | words                      | handshake
//  in      | in        | cmd, reg_addr, wdata       | in_valid / in_stall
//  out     | out       | rdata                      | out_valid / out_stall
//  cfg     | in        | cfg_index, cfg_data        | cfg_we
// each bus access spends a decode cycle that issues the media store read, whose
// byte is registered, and a finish cycle that uses the read byte and
// writes the store and state back; the result word is registered at its end.
// the next access is decoded in the finish cycle of the previous one, so one word
// per cycle is taken; a same-entry write is seen through a forwarding register.
// the input stalls only while a finished word waits in the stalled output register.
// reset clears control state but sets CMDE; the store is undefined until written.
module bubble_cassette_controller #(
    parameter int MEDIA_BYTES = 131072
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       cmd,
    input  wire logic [2:0] reg_addr,
    input  wire logic [7:0] wdata,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      rdata,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [0:0] cfg_data
);
    localparam int AW = $clog2(MEDIA_BYTES);

    logic [7:0] mem [MEDIA_BYTES];

    logic inserted_reg, large_reg, protect_reg;
    logic [7:0]  latch_reg, latch_next;
    logic [6:0]  off_reg, off_next;
    logic [15:0] pa_reg, pa_next, pc_reg, pc_next;
    logic [7:0]  lc_reg, lc_next;
    logic [4:0]  st_reg, st_next;
    logic [6:0]  er_reg, er_next;
    logic [1:0]  ad_reg, ad_next;

    // finish stage holds one access
    logic       f_valid_reg;
    logic       f_cmd_reg;
    logic [2:0] f_ra_reg;
    logic [7:0] f_wd_reg;
    logic       f_rdok_reg;
    logic [7:0] mem_q;
    logic       ov_valid_reg;
    logic [7:0] ov_data_reg;

    logic [6:0]  ps;
    logic [10:0] mask;
    logic [23:0] ms;
    assign ps   = large_reg ? bcc_pkg::PS_LARGE : bcc_pkg::PS_SMALL;
    assign mask = large_reg ? bcc_pkg::MASK_LARGE : bcc_pkg::MASK_SMALL;
    assign ms   = large_reg ? bcc_pkg::MS_LARGE : bcc_pkg::MS_SMALL;

    // the finish stage completes when the output register can take a word
    logic fin;
    assign fin = f_valid_reg && !(ov_valid_reg && out_stall);
    assign in_stall = f_valid_reg && !fin;
    logic acc;
    assign acc = in_valid && !in_stall;

    // store read address: the byte the finish stage may want, predicted from
    // the state left by the finish running in the same cycle
    logic [23:0] rd_addr_data, rd_addr_cmd, rd_addr_page;
    logic [6:0]  nxt_off;
    assign nxt_off = off_next + 7'd1;
    assign rd_addr_data = 24'({13'd0, pa_next[10:0] & mask} * {17'd0, ps})
                        + {17'd0, nxt_off};
    assign rd_addr_cmd  = 24'({13'd0, pa_next[10:0] & mask} * {17'd0, ps});
    // after a page completes, the next page start, from the advanced address
    logic [15:0] pa_adv;
    assign pa_adv = (pa_next + 16'd1) & {5'd0, mask};
    assign rd_addr_page = 24'({8'd0, pa_adv} * {17'd0, ps});

    // three candidate addresses on one read port: the decode cycle picks the
    // one the access can need. a data read needs either the next in-page byte
    // or the next page start, chosen by whether off+1 reaches the page size.
    logic [23:0] rd_addr;
    always_comb
    begin
        if (reg_addr == bcc_pkg::RA_CMD)
            rd_addr = rd_addr_cmd;
        else if (nxt_off == ps)
            rd_addr = rd_addr_page;
        else
            rd_addr = rd_addr_data;
    end

    // write to store happens in the finish cycle
    logic        wr_en;
    logic [23:0] wr_addr;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr[AW-1:0]] <= f_wd_reg;
        if (acc)
            mem_q <= mem[rd_addr[AW-1:0]];
    end

    // reads beyond the store give zero
    always_ff @(posedge clk)
    begin
        if (acc)
            f_rdok_reg <= rd_addr < 24'(MEDIA_BYTES);
    end

    // forwarding: a write in the same cycle to the address being read
    logic fwd_hit_reg;
    logic [7:0] fwd_data_reg;
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= f_wd_reg;
        end
    end
    logic [7:0] rbyte;
    assign rbyte = !f_rdok_reg ? 8'd0 : (fwd_hit_reg ? fwd_data_reg : mem_q);

    // finish stage: full behavior of one access
    logic [7:0] res;
    logic [23:0] off_rd, off_wr;
    logic [6:0] inc;
    always_comb
    begin
        latch_next = latch_reg; off_next = off_reg; pa_next = pa_reg;
        pc_next = pc_reg; lc_next = lc_reg; st_next = st_reg;
        er_next = er_reg; ad_next = ad_reg; res = 8'd0;
        wr_en = 1'b0; wr_addr = 24'd0;
        inc = off_reg + 7'd1;
        off_rd = 24'({13'd0, pa_reg[10:0] & mask} * {17'd0, ps}) + {17'd0, off_reg};
        off_wr = 24'({8'd0, pa_reg} * {17'd0, ps}) + {17'd0, off_reg};
        if (fin)
        begin
            if (!f_cmd_reg)
            begin
                unique case (f_ra_reg)
                    bcc_pkg::RA_DATA:
                    begin
                        res = latch_reg;
                        if (st_reg[bcc_pkg::ST_RDA])
                        begin
                            if (off_rd >= ms)
                            begin
                                er_next[bcc_pkg::ER_POVR] = 1'b1;
                                st_next[bcc_pkg::ST_ERR] = 1'b1;
                                st_next[bcc_pkg::ST_CMDE] = 1'b1;
                                ad_next[bcc_pkg::AD_READ] = 1'b0;
                            end
                            else
                            begin
                                ad_next = 2'b01;
                                off_next = inc;
                                if (inc == ps)
                                begin
                                    st_next[bcc_pkg::ST_BUSY] = 1'b0;
                                    st_next[bcc_pkg::ST_RDA] = 1'b0;
                                    st_next[bcc_pkg::ST_CMDE] = 1'b1;
                                    off_next = 7'd0;
                                    if (pc_reg > 16'd1)
                                    begin
                                        pc_next = pc_reg - 16'd1;
                                        st_next[bcc_pkg::ST_BUSY] = 1'b1;
                                        st_next[bcc_pkg::ST_CMDE] = 1'b0;
                                        pa_next = (pa_reg + 16'd1) & {5'd0, mask};
                                        latch_next = rbyte;
                                    end
                                    else
                                    begin
                                        pc_next = 16'd0;
                                        ad_next[bcc_pkg::AD_READ] = 1'b0;
                                    end
                                end
                                else
                                begin
                                    latch_next = rbyte;
                                    st_next[bcc_pkg::ST_CMDE] = 1'b0;
                                    st_next[bcc_pkg::ST_BUSY] = 1'b1;
                                end
                            end
                        end
                    end
                    bcc_pkg::RA_STATUS:
                    begin
                        if (!inserted_reg)
                        begin
                            st_next[bcc_pkg::ST_CMDE] = 1'b1;
                            st_next[bcc_pkg::ST_ERR] = 1'b1;
                            er_next[bcc_pkg::ER_EJECT] = 1'b1;
                        end
                        res = {st_next[bcc_pkg::ST_CMDE], st_next[bcc_pkg::ST_TDRA],
                               st_next[bcc_pkg::ST_RDA], !inserted_reg, 1'b0,
                               protect_reg, st_next[bcc_pkg::ST_ERR],
                               st_next[bcc_pkg::ST_BUSY]};
                        if (!inserted_reg)
                            st_next[bcc_pkg::ST_BUSY] = 1'b0;
                        if (lc_reg == bcc_pkg::CMD_READ && inserted_reg
                            && ad_reg[bcc_pkg::AD_READ])
                            st_next[bcc_pkg::ST_RDA] = 1'b1;
                        else if (lc_reg == bcc_pkg::CMD_WRITE && inserted_reg
                            && ad_reg[bcc_pkg::AD_WRITE])
                            st_next[bcc_pkg::ST_TDRA] = 1'b1;
                    end
                    bcc_pkg::RA_ERROR:
                        res = {er_reg[bcc_pkg::ER_EJECT], 1'b0, er_reg[5:0]};
                    default:
                        res = 8'hff;
                endcase
            end
            else
            begin
                unique case (f_ra_reg)
                    bcc_pkg::RA_DATA:
                    begin
                        latch_next = f_wd_reg;
                        if (st_reg[bcc_pkg::ST_TDRA])
                        begin
                            if (off_wr >= ms)
                            begin
                                er_next[bcc_pkg::ER_POVR] = 1'b1;
                                st_next[bcc_pkg::ST_ERR] = 1'b1;
                                st_next[bcc_pkg::ST_CMDE] = 1'b1;
                            end
                            else
                            begin
                                wr_addr = off_rd;
                                wr_en = off_rd < 24'(MEDIA_BYTES);
                                ad_next = 2'b10;
                                off_next = inc;
                                if (inc == ps)
                                begin
                                    st_next[bcc_pkg::ST_BUSY] = 1'b0;
                                    st_next[bcc_pkg::ST_TDRA] = 1'b0;
                                    st_next[bcc_pkg::ST_ERR] = 1'b0;
                                    st_next[bcc_pkg::ST_CMDE] = 1'b1;
                                    off_next = 7'd0;
                                    if (pc_reg > 16'd1)
                                    begin
                                        pc_next = pc_reg - 16'd1;
                                        st_next[bcc_pkg::ST_BUSY] = 1'b1;
                                        st_next[bcc_pkg::ST_CMDE] = 1'b0;
                                        pa_next = (pa_reg + 16'd1) & {5'd0, mask};
                                    end
                                    else
                                    begin
                                        pc_next = 16'd0;
                                        ad_next[bcc_pkg::AD_WRITE] = 1'b0;
                                    end
                                end
                            end
                        end
                    end
                    bcc_pkg::RA_CMD:
                    begin
                        st_next = 5'd0; er_next = 7'd0; lc_next = f_wd_reg;
                        unique case (f_wd_reg)
                            bcc_pkg::CMD_READ:
                            begin
                                off_next = 7'd0; ad_next = 2'b00;
                                if (!inserted_reg)
                                begin
                                    st_next = 5'b10010; er_next = 7'b1000010;
                                end
                                else
                                begin
                                    latch_next = rbyte;
                                    st_next[bcc_pkg::ST_RDA] = 1'b1;
                                    ad_next = 2'b01;
                                end
                            end
                            bcc_pkg::CMD_WRITE:
                            begin
                                ad_next = 2'b00;
                                if (!inserted_reg)
                                begin
                                    st_next = 5'b10011; er_next = 7'b1000010;
                                end
                                else if (protect_reg)
                                    st_next = 5'b10000;
                                else
                                begin
                                    st_next = 5'b01001;
                                    off_next = 7'd0;
                                    ad_next = 2'b10;
                                end
                            end
                            bcc_pkg::CMD_CLR_A, bcc_pkg::CMD_CLR_B:
                            begin
                                latch_next = 8'd0; pa_next = 16'd0;
                                pc_next = 16'd0; ad_next = 2'b00;
                            end
                            default:
                            begin
                                st_next = 5'b10010; er_next = 7'b0000001;
                            end
                        endcase
                    end
                    bcc_pkg::RA_PA_HI: pa_next = {f_wd_reg, pa_reg[7:0]};
                    bcc_pkg::RA_PA_LO: pa_next = {pa_reg[15:8], f_wd_reg};
                    bcc_pkg::RA_PC_HI: pc_next = {f_wd_reg, pc_reg[7:0]};
                    bcc_pkg::RA_PC_LO: pc_next = {pc_reg[15:8], f_wd_reg};
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inserted_reg <= 1'b0; large_reg <= 1'b0; protect_reg <= 1'b0;
            latch_reg <= 8'd0; off_reg <= 7'd0; pa_reg <= 16'd0; pc_reg <= 16'd0;
            lc_reg <= 8'd0; st_reg <= 5'b10000; er_reg <= 7'd0; ad_reg <= 2'd0;
            f_valid_reg <= 1'b0; ov_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bcc_pkg::CFG_INSERTED: inserted_reg <= cfg_data[0];
                    bcc_pkg::CFG_LARGE:    large_reg    <= cfg_data[0];
                    bcc_pkg::CFG_PROTECT:  protect_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
            latch_reg <= latch_next; off_reg <= off_next; pa_reg <= pa_next;
            pc_reg <= pc_next; lc_reg <= lc_next; st_reg <= st_next;
            er_reg <= er_next; ad_reg <= ad_next;
            if (acc)
                f_valid_reg <= 1'b1;
            else if (fin)
                f_valid_reg <= 1'b0;
            if (fin)
                ov_valid_reg <= 1'b1;
            else if (!out_stall)
                ov_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            f_cmd_reg <= cmd; f_ra_reg <= reg_addr; f_wd_reg <= wdata;
        end
        if (fin)
            ov_data_reg <= res;
    end

    assign out_valid = ov_valid_reg;
    assign rdata = ov_data_reg;
endmodule
`default_nettype wire
